/* design/sfpr_pkg.sv */
// Package for the sync framed packet receiver.
// Holds shared codes, constants and the result record type; no dependencies.
package sfpr_pkg;

   localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
   localparam logic [7:0]  SUM_SEED      = 8'h55;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_TIMEOUT  = 2'd2;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_CHECK   = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [2:0] packet_id;
      logic [4:0] payload_length;
      logic [4:0] payload_index;
      logic [7:0] payload_byte;
      logic       last;
   } rsp_type;

endpackage

/* design/sfpr_ifs.sv */
// Request and response channel interfaces for the packet receiver.
// Does not depend on sfpr_pkg; the response fields are declared one by one.
interface sfpr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface sfpr_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] status;
   logic [2:0] packet_id;
   logic [4:0] payload_length;
   logic [4:0] payload_index;
   logic [7:0] payload_byte;
   logic       last;
   modport source (output valid, output kind, output status, output packet_id,
                   output payload_length, output payload_index, output payload_byte,
                   output last, input ready);
   modport sink (input valid, input kind, input status, input packet_id,
                 input payload_length, input payload_index, input payload_byte,
                 input last, output ready);
endinterface

/* design/sync_framed_packet_receiver.sv */
// Top level of the sync framed packet receiver.
// Depends on sfpr_pkg, sfpr_ifs, sfpr_core and sfpr_out_reg.
//
// Requests on req_bus carry either one received byte (op 0) or one time tick
// (op 1). The receiver hunts for sync byte 0xAA, takes a header byte (length
// in bits 7..3, id in bits 2..0), a checksum byte and the payload. Every
// payload byte but the last leaves on rsp_bus as a payload response; the last
// one rides on the status response (ok or checksum mismatch). Timeout status
// is sent when the tick count since hunting began reaches csr timeout.
// csr_wr_en / csr_wr_data write the 16-bit tick timeout (reset 1000).
//
// One request per cycle while ready is high. A response appears on rsp_bus in the
// cycle after its request is taken, from a single output register. req_bus.ready
// is high while that register is empty or being emptied, so a stalled consumer
// holds off new requests after one response is pending.
// Synchronous reset returns to hunting with an empty output register; no
// clearing pass is needed.
module sync_framed_packet_receiver (
   input  logic        clock,
   input  logic        reset,
   sfpr_req_if.sink    req_bus,
   sfpr_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic              fire;
   logic              can_load;
   logic              res_valid;
   sfpr_pkg::rsp_type res;

   assign req_bus.ready = can_load;
   assign fire          = req_bus.valid && can_load;

   sfpr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .op          (req_bus.op),
      .rx_byte     (req_bus.rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   sfpr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .can_load  (can_load),
      .rsp       (rsp_bus)
   );

endmodule

/* design/sfpr_core.sv */
// Framing state machine, checksum and tick timeout of the packet receiver.
// Depends on sfpr_pkg; produces at most one response record per request.
module sfpr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                op,
   input  logic [7:0]          rx_byte,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   output logic                res_valid,
   output sfpr_pkg::rsp_type   res
);

   sfpr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  expect_ff, expect_in;
   logic [7:0]  sum_ff, sum_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] timeout_ff;
   logic [15:0] ticks_inc;
   logic [7:0]  sum_new;
   logic [4:0]  hdr_len;
   logic        restart;

   assign hdr_len   = header_ff[7:3];
   assign sum_new   = sum_ff ^ rx_byte;
   assign ticks_inc = (elapsed_ff == sfpr_pkg::TICKS_MAX) ? elapsed_ff : elapsed_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      expect_in  = expect_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      restart    = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      if (fire) begin
         if (op == sfpr_pkg::OP_TICK) begin
            elapsed_in = ticks_inc;
            if (ticks_inc >= timeout_ff) begin
               res_valid  = 1'b1;
               res.kind   = sfpr_pkg::KIND_STATUS;
               res.status = sfpr_pkg::ST_TIMEOUT;
               res.last   = 1'b1;
               restart    = 1'b1;
            end
         end else if (elapsed_ff >= timeout_ff) begin
            res_valid  = 1'b1;
            res.kind   = sfpr_pkg::KIND_STATUS;
            res.status = sfpr_pkg::ST_TIMEOUT;
            res.last   = 1'b1;
            restart    = 1'b1;
         end else begin
            case (phase_ff)
               sfpr_pkg::PH_HUNT: begin
                  if (rx_byte == sfpr_pkg::SYNC_BYTE) phase_in = sfpr_pkg::PH_HEADER;
               end
               sfpr_pkg::PH_HEADER: begin
                  header_in = rx_byte;
                  sum_in    = sfpr_pkg::SUM_SEED ^ rx_byte;
                  count_in  = 5'd0;
                  phase_in  = sfpr_pkg::PH_CHECK;
               end
               sfpr_pkg::PH_CHECK: begin
                  expect_in = rx_byte;
                  if (hdr_len == 5'd0) begin
                     res_valid          = 1'b1;
                     res.kind           = sfpr_pkg::KIND_STATUS;
                     res.status         = (sum_ff == rx_byte) ? sfpr_pkg::ST_OK
                                                              : sfpr_pkg::ST_MISMATCH;
                     res.packet_id      = header_ff[2:0];
                     res.payload_length = hdr_len;
                     res.last           = 1'b1;
                     restart            = 1'b1;
                  end else begin
                     phase_in = sfpr_pkg::PH_PAYLOAD;
                  end
               end
               sfpr_pkg::PH_PAYLOAD: begin
                  sum_in             = sum_new;
                  res_valid          = 1'b1;
                  res.packet_id      = header_ff[2:0];
                  res.payload_length = hdr_len;
                  res.payload_index  = count_ff;
                  res.payload_byte   = rx_byte;
                  if (({1'b0, count_ff} + 6'd1) >= {1'b0, hdr_len}) begin
                     res.kind   = sfpr_pkg::KIND_STATUS;
                     res.status = (sum_new == expect_ff) ? sfpr_pkg::ST_OK
                                                         : sfpr_pkg::ST_MISMATCH;
                     res.last   = 1'b1;
                     restart    = 1'b1;
                  end else begin
                     res.kind = sfpr_pkg::KIND_PAYLOAD;
                     count_in = count_ff + 5'd1;
                  end
               end
               default: phase_in = sfpr_pkg::PH_HUNT;
            endcase
         end
         if (restart) begin
            phase_in   = sfpr_pkg::PH_HUNT;
            expect_in  = 8'd0;
            sum_in     = 8'd0;
            count_in   = 5'd0;
            elapsed_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sfpr_pkg::PH_HUNT;
         header_ff  <= 8'd0;
         expect_ff  <= 8'd0;
         sum_ff     <= 8'd0;
         count_ff   <= 5'd0;
         elapsed_ff <= 16'd0;
         timeout_ff <= sfpr_pkg::TIMEOUT_RESET;
      end else begin
         phase_ff   <= phase_in;
         header_ff  <= header_in;
         expect_ff  <= expect_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         if (csr_wr_en) timeout_ff <= csr_wr_data;
      end
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   a_status_restarts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.last) |=> (phase_ff == sfpr_pkg::PH_HUNT && elapsed_ff == 16'd0
                                   && count_ff == 5'd0))
      else $error("state not restarted after a status");

   a_payload_phase: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == sfpr_pkg::KIND_PAYLOAD) |-> phase_ff == sfpr_pkg::PH_PAYLOAD)
      else $error("payload result outside payload phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sfpr_pkg::PH_PAYLOAD) |-> count_ff < hdr_len)
      else $error("payload count ran past header length");

endmodule

/* design/sfpr_out_reg.sv */
// Response output register of the packet receiver.
// Depends on sfpr_pkg and sfpr_rsp_if; refills in the cycle the held response leaves.
module sfpr_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sfpr_pkg::rsp_type load_data,
   output logic              can_load,
   sfpr_rsp_if.source        rsp
);

   logic              valid_ff, valid_in;
   sfpr_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = data_ff.kind;
   assign rsp.status         = data_ff.status;
   assign rsp.packet_id      = data_ff.packet_id;
   assign rsp.payload_length = data_ff.payload_length;
   assign rsp.payload_index  = data_ff.payload_index;
   assign rsp.payload_byte   = data_ff.payload_byte;
   assign rsp.last           = data_ff.last;

endmodule

/* bench/sync_framed_packet_receiver_tb.sv */
// Self-checking bench for sync_framed_packet_receiver: a directed table, then random frames.
// Depends on sfpr_pkg, the sfpr_req_if / sfpr_rsp_if interfaces and the receiver RTL.
module sync_framed_packet_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 800_000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned REPORT_MAX   = 10;

   localparam sfpr_pkg::rsp_type TIMEOUT_RSP = {sfpr_pkg::KIND_STATUS, sfpr_pkg::ST_TIMEOUT,
                                                3'd0, 5'd0, 5'd0, 8'h00, 1'b1};

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_mode_type;
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      check_mode_type    check;
      logic              op;
      logic [7:0]        data;
      logic [15:0]       csr_value;
      sfpr_pkg::rsp_type want;
   } script_row_type;

   typedef struct {
      check_mode_type    check;
      sfpr_pkg::rsp_type want;
   } req_note_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   sfpr_req_if req_bus();
   sfpr_rsp_if rsp_bus();

   sync_framed_packet_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   req_note_type      req_notes [$];
   sfpr_pkg::rsp_type awaited_rsp [$];
   script_row_type    script [$];

   // receiver model state
   logic [15:0]         timeout_lim;
   sfpr_pkg::phase_type rx_phase;
   logic [7:0]          hdr_byte;
   logic [7:0]          sum_rx;
   logic [7:0]          sum_run;
   logic [4:0]          taken;
   logic [15:0]         ticks;

   int unsigned sent_count    = 0;
   int unsigned rsp_count     = 0;
   int unsigned ok_count      = 0;
   int unsigned bad_count     = 0;
   int unsigned expired_count = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned calm_left     = 0;
   int unsigned tick_pct      = 0;
   bit          hold_off_req  = 1'b0;

   function automatic bit frame_step(input logic op, input logic [7:0] d,
                                     output sfpr_pkg::rsp_type r);
      bit         expired;
      bit         closing;
      logic [4:0] plen;
      r = '0;
      closing = 1'b0;
      plen = hdr_byte[7:3];
      if (op == sfpr_pkg::OP_TICK && ticks != sfpr_pkg::TICKS_MAX)
         ticks = ticks + 16'd1;
      expired = (ticks >= timeout_lim);
      if (!expired && op == sfpr_pkg::OP_BYTE) begin
         case (rx_phase)
            sfpr_pkg::PH_HUNT: begin
               if (d == sfpr_pkg::SYNC_BYTE)
                  rx_phase = sfpr_pkg::PH_HEADER;
            end
            sfpr_pkg::PH_HEADER: begin
               hdr_byte = d;
               sum_run = sfpr_pkg::SUM_SEED ^ d;
               taken = '0;
               rx_phase = sfpr_pkg::PH_CHECK;
            end
            sfpr_pkg::PH_CHECK: begin
               sum_rx = d;
               if (plen == 5'd0)
                  closing = 1'b1;
               else
                  rx_phase = sfpr_pkg::PH_PAYLOAD;
            end
            default: begin
               sum_run = sum_run ^ d;
               r.payload_index = taken;
               r.payload_byte = d;
               // last payload byte rides on the status
               if (int'(taken) + 1 >= int'(plen)) begin
                  closing = 1'b1;
               end else begin
                  r.kind = sfpr_pkg::KIND_PAYLOAD;
                  r.packet_id = hdr_byte[2:0];
                  r.payload_length = plen;
                  taken = taken + 5'd1;
                  return 1'b1;
               end
            end
         endcase
      end
      if (expired) begin
         r.kind = sfpr_pkg::KIND_STATUS;
         r.status = sfpr_pkg::ST_TIMEOUT;
         r.last = 1'b1;
      end else if (closing) begin
         r.kind = sfpr_pkg::KIND_STATUS;
         r.status = (sum_run == sum_rx) ? sfpr_pkg::ST_OK : sfpr_pkg::ST_MISMATCH;
         r.packet_id = hdr_byte[2:0];
         r.payload_length = plen;
         r.last = 1'b1;
      end else begin
         return 1'b0;
      end
      rx_phase = sfpr_pkg::PH_HUNT;
      sum_rx = '0;
      sum_run = '0;
      taken = '0;
      ticks = '0;
      return 1'b1;
   endfunction

   function automatic string rsp_text(input sfpr_pkg::rsp_type r);
      return $sformatf("kind %0d status %0d id %0d len %0d idx %0d byte %02h last %0d",
                       r.kind, r.status, r.packet_id, r.payload_length, r.payload_index,
                       r.payload_byte, r.last);
   endfunction

   function automatic void note_fault(input string what, input sfpr_pkg::rsp_type want,
                                      input sfpr_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("[%0t] %s: expected {%s} got {%s}", $time, what, rsp_text(want),
                  rsp_text(got));
   endfunction

   always @(posedge clock) begin
      sfpr_pkg::rsp_type got;
      sfpr_pkg::rsp_type pred;
      req_note_type      note;
      bit                made;
      if (reset === 1'b0) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = {rsp_bus.kind, rsp_bus.status, rsp_bus.packet_id, rsp_bus.payload_length,
                   rsp_bus.payload_index, rsp_bus.payload_byte, rsp_bus.last};
            rsp_count++;
            if (got.kind == sfpr_pkg::KIND_STATUS) begin
               if (got.status == sfpr_pkg::ST_OK)
                  ok_count++;
               else if (got.status == sfpr_pkg::ST_MISMATCH)
                  bad_count++;
               else
                  expired_count++;
            end
            if (awaited_rsp.size() == 0) begin
               note_fault("response with none awaited", '0, got);
            end else begin
               pred = awaited_rsp.pop_front();
               if (got !== pred)
                  note_fault("response mismatch", pred, got);
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            note = req_notes.pop_front();
            made = frame_step(req_bus.op, req_bus.rx_byte, pred);
            if (note.check == CHK_GIVEN)
               awaited_rsp.push_back(note.want);
            else if (note.check == CHK_MODEL && made)
               awaited_rsp.push_back(pred);
         end
      end
   end

   task automatic send_req(input logic op, input logic [7:0] d, input check_mode_type check,
                           input sfpr_pkg::rsp_type want);
      int unsigned gap;
      int unsigned r;
      gap = 0;
      r = $urandom_range(0, 99);
      if (calm_left != 0)
         calm_left--;
      else if (r < 4)
         calm_left = $urandom_range(10, 60);
      else if (r >= 94)
         gap = $urandom_range(10, 40);
      else if (r >= 55)
         gap = $urandom_range(1, 3);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_notes.push_back('{check, want});
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.rx_byte <= d;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sent_count++;
   endtask

   task automatic offer_byte(input logic [7:0] d);
      if ($urandom_range(0, 99) < tick_pct)
         send_req(sfpr_pkg::OP_TICK, 8'($urandom), CHK_MODEL, '0);
      send_req(sfpr_pkg::OP_BYTE, d, CHK_MODEL, '0);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_rsp.size() != 0 || req_notes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      timeout_lim = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_req(input check_mode_type check, input logic op, input logic [7:0] d,
                          input sfpr_pkg::rsp_type want);
      script.push_back('{ROW_REQ, check, op, d, 16'd0, want});
   endtask

   task automatic add_csr(input logic [15:0] v);
      script.push_back('{ROW_CSR, CHK_NONE, sfpr_pkg::OP_BYTE, 8'h00, v,
                         sfpr_pkg::rsp_type'(0)});
   endtask

   // mostly well-formed frames; the rest noise, cut-short frames and tick bursts
   task automatic run_frames(input int unsigned quota);
      logic [7:0]  body [32];
      logic [7:0]  hdr;
      logic [7:0]  chk;
      logic [7:0]  b;
      int unsigned plen;
      int unsigned stop_at;
      int unsigned pick;
      stop_at = sent_count + quota;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            repeat ($urandom_range(0, 2)) begin
               b = 8'($urandom);
               offer_byte((b == sfpr_pkg::SYNC_BYTE) ? sfpr_pkg::SUM_SEED : b);
            end
            pick = $urandom_range(0, 9);
            plen = (pick == 0) ? 0 : (pick == 1) ? 31 : $urandom_range(1, 8);
            hdr = {5'(plen), 3'($urandom)};
            chk = sfpr_pkg::SUM_SEED ^ hdr;
            for (int i = 0; i < plen; i++) begin
               body[i] = 8'($urandom);
               chk ^= body[i];
            end
            if ($urandom_range(0, 4) == 0)
               chk ^= 8'($urandom_range(1, 255));
            offer_byte(sfpr_pkg::SYNC_BYTE);
            offer_byte(hdr);
            offer_byte(chk);
            for (int i = 0; i < plen; i++)
               offer_byte(body[i]);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) offer_byte(8'($urandom));
         end else if (pick < 93) begin
            offer_byte(sfpr_pkg::SYNC_BYTE);
            repeat ($urandom_range(0, 4)) offer_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 12))
               send_req(sfpr_pkg::OP_TICK, 8'($urandom), CHK_MODEL, '0);
         end
      end
   endtask

   // response side: idle stretches, random stalls, one long hold-off on request
   initial begin
      bit          level;
      int unsigned span;
      level = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            level = 1'b0;
            span = HOLD_CYCLES;
         end else if (level == 1'b0) begin
            level = 1'b1;
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
         end else begin
            level = 1'b0;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
         end
         rsp_bus.ready <= level;
         repeat (span) @(posedge clock);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped at the cycle limit, %0d responses still awaited", awaited_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned    lim_list [8];
      int unsigned    quota_list [8];
      int unsigned    pct_list [8];
      script_row_type row;

      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.op      <= sfpr_pkg::OP_BYTE;
      req_bus.rx_byte <= '0;

      lim_list   = '{0, 1, 5, 17, 60, 255, 65535, 0};
      quota_list = '{40, 60, 150, 200, 200, 200, 150, 100};
      pct_list   = '{10, 20, 20, 20, 25, 30, 3, 15};
      lim_list[7] = $urandom_range(2, 40);

      timeout_lim = sfpr_pkg::TIMEOUT_RESET;
      rx_phase = sfpr_pkg::PH_HUNT;
      hdr_byte = '0;
      sum_rx = '0;
      sum_run = '0;
      taken = '0;
      ticks = '0;

      // hunting, empty packets, a two-byte packet, then timeouts at tiny limits
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, 8'h00, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, 8'hFF, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_TICK, 8'h5A, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, sfpr_pkg::SYNC_BYTE, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, 8'h00, '0);
      add_req(CHK_GIVEN, sfpr_pkg::OP_BYTE, 8'h55,
              {sfpr_pkg::KIND_STATUS, sfpr_pkg::ST_OK, 3'd0, 5'd0, 5'd0, 8'h00, 1'b1});
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, sfpr_pkg::SYNC_BYTE, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, 8'h07, '0);
      add_req(CHK_GIVEN, sfpr_pkg::OP_BYTE, 8'h00,
              {sfpr_pkg::KIND_STATUS, sfpr_pkg::ST_MISMATCH, 3'd7, 5'd0, 5'd0, 8'h00, 1'b1});
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, sfpr_pkg::SYNC_BYTE, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, 8'h12, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, 8'hB8, '0);
      add_req(CHK_GIVEN, sfpr_pkg::OP_BYTE, 8'hFF,
              {sfpr_pkg::KIND_PAYLOAD, sfpr_pkg::ST_OK, 3'd2, 5'd2, 5'd0, 8'hFF, 1'b0});
      add_req(CHK_GIVEN, sfpr_pkg::OP_BYTE, 8'h00,
              {sfpr_pkg::KIND_STATUS, sfpr_pkg::ST_OK, 3'd2, 5'd2, 5'd1, 8'h00, 1'b1});
      add_csr(16'd2);
      add_req(CHK_NONE, sfpr_pkg::OP_BYTE, sfpr_pkg::SYNC_BYTE, '0);
      add_req(CHK_NONE, sfpr_pkg::OP_TICK, 8'h00, '0);
      add_req(CHK_GIVEN, sfpr_pkg::OP_TICK, 8'hFF, TIMEOUT_RSP);
      add_csr(16'd0);
      add_req(CHK_GIVEN, sfpr_pkg::OP_BYTE, 8'h33, TIMEOUT_RSP);
      add_req(CHK_GIVEN, sfpr_pkg::OP_TICK, 8'h00, TIMEOUT_RSP);
      add_csr(16'hFFFF);
      add_req(CHK_MODEL, sfpr_pkg::OP_BYTE, sfpr_pkg::SYNC_BYTE, '0);
      add_req(CHK_MODEL, sfpr_pkg::OP_BYTE, 8'hFF, '0);
      add_req(CHK_MODEL, sfpr_pkg::OP_BYTE, 8'h3C, '0);
      add_req(CHK_MODEL, sfpr_pkg::OP_BYTE, 8'h01, '0);
      add_req(CHK_MODEL, sfpr_pkg::OP_BYTE, sfpr_pkg::SYNC_BYTE, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_CSR) begin
            settle();
            set_timeout(row.csr_value);
         end else begin
            send_req(row.op, row.data, row.check, row.want);
         end
      end

      foreach (lim_list[i]) begin
         settle();
         set_timeout(16'(lim_list[i]));
         tick_pct = pct_list[i];
         if (i == 4)
            hold_off_req = 1'b1;
         run_frames(quota_list[i]);
      end
      settle();

      $display("%0d requests over %0d cycles, tick limit stepped from 0 up to 65535",
               sent_count, cycle_count);
      $display("%0d responses: %0d ok, %0d checksum errors, %0d timeouts; %0d faults",
               rsp_count, ok_count, bad_count, expired_count, fail_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
